>>> hw/rtl/sftd_pkg.sv
// sftd_pkg: shared types and constants of the status frame target decoder
// header bytes, phase and kind codes, the frame descriptor and config index codes
// no dependencies
package sftd_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] HDR_THIRD  = 8'hDC;
    localparam logic [7:0] LEN_MASK   = 8'h3F;
    localparam logic [5:0] MIN_LEN    = 6'd3;
    // a body of at least 22 bytes needs a length code of at least 25
    localparam logic [5:0] MIN_FULL_LEN = 6'd25;

    localparam logic [7:0]  EXPECTED_TYPE_RST = 8'h40;
    localparam logic [30:0] LAT_LIMIT_RST     = 31'd900000000;
    localparam logic [30:0] LON_LIMIT_RST     = 31'd1800000000;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [1:0] CFG_EXPECTED_TYPE = 2'd0;
    localparam logic [1:0] CFG_LAT_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_LON_LIMIT     = 2'd2;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_GOT1   = 3'd1,
        PH_GOT2   = 3'd2,
        PH_LEN    = 3'd3,
        PH_FRAME  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_OK       = 3'd0,
        KIND_REJECT   = 3'd1,
        KIND_CSUM_BAD = 3'd2,
        KIND_OTHER    = 3'd3,
        KIND_SHORT    = 3'd4
    } t_kind;

    // frame outcome as the front end sees it; KIND_OK still awaits the limit check
    typedef struct packed {
        t_kind       kind;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [15:0] alt;
        logic [31:0] count;
    } t_desc;

    typedef struct packed {
        logic [30:0] lat_limit;
        logic [30:0] lon_limit;
    } t_limits;

endpackage

>>> hw/rtl/sftd_front.sv
// sftd_front: byte parser; hunts the header, tracks checksum and fields,
// hands the queue a descriptor per frame ended or too short, none if cut
// depends on sftd_pkg
module sftd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_datagram_end,
    input  logic [7:0]          i_expected_type,
    output logic                o_push,
    output sftd_pkg::t_desc     o_desc
);

    sftd_pkg::t_phase r_phase, n_phase;
    logic [5:0]  r_len, n_len;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_lat, n_lat;
    logic [31:0] r_lon, n_lon;
    logic [15:0] r_alt, n_alt;
    logic [31:0] r_count, n_count;

    logic [5:0] ln;
    logic [5:0] idx;
    logic       is_csum;

    assign ln      = 6'(i_data_byte & sftd_pkg::LEN_MASK);
    assign idx     = r_pos - 6'd1;
    assign is_csum = (r_pos == (r_len - 6'd2));

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                sftd_pkg::PH_SEARCH: begin
                    if (i_data_byte == sftd_pkg::HDR_FIRST) n_phase = sftd_pkg::PH_GOT1;
                end
                sftd_pkg::PH_GOT1: begin
                    if (i_data_byte == sftd_pkg::HDR_SECOND)     n_phase = sftd_pkg::PH_GOT2;
                    else if (i_data_byte == sftd_pkg::HDR_FIRST) n_phase = sftd_pkg::PH_GOT1;
                    else                                         n_phase = sftd_pkg::PH_SEARCH;
                end
                sftd_pkg::PH_GOT2: begin
                    if (i_data_byte == sftd_pkg::HDR_THIRD)      n_phase = sftd_pkg::PH_LEN;
                    else if (i_data_byte == sftd_pkg::HDR_FIRST) n_phase = sftd_pkg::PH_GOT1;
                    else                                         n_phase = sftd_pkg::PH_SEARCH;
                end
                sftd_pkg::PH_LEN: begin
                    n_phase = (ln < sftd_pkg::MIN_LEN) ? sftd_pkg::PH_SEARCH
                                                       : sftd_pkg::PH_FRAME;
                end
                sftd_pkg::PH_FRAME: begin
                    if (is_csum) n_phase = sftd_pkg::PH_SEARCH;
                end
                default: n_phase = sftd_pkg::PH_SEARCH;
            endcase
            // end of datagram always drops back to hunting
            if (i_datagram_end) n_phase = sftd_pkg::PH_SEARCH;
        end
    end

    // datapath and descriptor
    always_comb begin
        n_len   = r_len;
        n_pos   = r_pos;
        n_xor   = r_xor;
        n_type  = r_type;
        n_lat   = r_lat;
        n_lon   = r_lon;
        n_alt   = r_alt;
        n_count = r_count;
        o_push  = 1'b0;
        o_desc  = '{kind: sftd_pkg::KIND_SHORT, lat: 32'd0, lon: 32'd0,
                    alt: 16'd0, count: r_count};
        if (i_accept) begin
            unique case (r_phase)
                sftd_pkg::PH_LEN: begin
                    if (ln < sftd_pkg::MIN_LEN) begin
                        o_push = 1'b1;
                    end else begin
                        n_len  = ln;
                        n_xor  = i_data_byte;
                        n_pos  = 6'd0;
                        n_type = 8'd0;
                        n_lat  = 32'd0;
                        n_lon  = 32'd0;
                        n_alt  = 16'd0;
                    end
                end
                sftd_pkg::PH_FRAME: begin
                    if (is_csum) begin
                        o_push = 1'b1;
                        if (i_data_byte != r_xor) begin
                            o_desc.kind = sftd_pkg::KIND_CSUM_BAD;
                        end else if (r_type != i_expected_type) begin
                            o_desc.kind = sftd_pkg::KIND_OTHER;
                        end else begin
                            n_count      = r_count + 32'd1;
                            o_desc.count = n_count;
                            if (r_len >= sftd_pkg::MIN_FULL_LEN) begin
                                o_desc.kind = sftd_pkg::KIND_OK;
                                o_desc.lat  = r_lat;
                                o_desc.lon  = r_lon;
                                o_desc.alt  = r_alt;
                            end
                        end
                    end else begin
                        n_xor = r_xor ^ i_data_byte;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == 6'd0) begin
                            n_type = i_data_byte;
                        end else begin
                            case (idx) inside
                                [6'd12:6'd15]: n_lat = {r_lat[23:0], i_data_byte};
                                [6'd16:6'd19]: n_lon = {r_lon[23:0], i_data_byte};
                                [6'd20:6'd21]: n_alt = {r_alt[7:0], i_data_byte};
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sftd_pkg::PH_SEARCH;
            r_count <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_pos  <= n_pos;
        r_xor  <= n_xor;
        r_type <= n_type;
        r_lat  <= n_lat;
        r_lon  <= n_lon;
        r_alt  <= n_alt;
    end

endmodule

>>> hw/rtl/sftd_queue.sv
// sftd_queue: short descriptor queue between parser and result stage
// depends on sftd_pkg
module sftd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sftd_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output sftd_pkg::t_desc o_head
);

    localparam int QPTR_CNT_W = sftd_pkg::QPTR_W + 1;
    localparam logic [QPTR_CNT_W-1:0] DEPTH_CNT = QPTR_CNT_W'(sftd_pkg::QDEPTH);

    sftd_pkg::t_desc r_mem [sftd_pkg::QDEPTH];
    logic [sftd_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_CNT_W-1:0]       r_cnt;

    assign o_full  = (r_cnt == DEPTH_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hw/rtl/sftd_back.sv
// sftd_back: result stage; applies the coordinate limits and holds the result
// in an output register under the output handshake
// depends on sftd_pkg
module sftd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  sftd_pkg::t_desc     i_head,
    input  sftd_pkg::t_limits   i_limits,
    input  logic                i_ready,
    output logic                o_pop,
    output logic                o_valid,
    output logic [2:0]          o_frame_kind,
    output logic signed [31:0]  o_latitude,
    output logic signed [31:0]  o_longitude,
    output logic signed [15:0]  o_altitude,
    output logic [31:0]         o_good_frames
);

    typedef sftd_pkg::t_kind t_kind_alias;

    logic        r_valid;
    t_kind_alias r_kind;
    logic [31:0] r_lat, r_lon;
    logic [15:0] r_alt;
    logic [31:0] r_cnt;

    logic [31:0] mag_lat, mag_lon;
    logic        bad;
    sftd_pkg::t_kind n_kind;

    assign mag_lat = i_head.lat[31] ? (32'd0 - i_head.lat) : i_head.lat;
    assign mag_lon = i_head.lon[31] ? (32'd0 - i_head.lon) : i_head.lon;
    assign bad = ((i_head.lat == 32'd0) && (i_head.lon == 32'd0))
              || (mag_lat > {1'b0, i_limits.lat_limit})
              || (mag_lon > {1'b0, i_limits.lon_limit});

    always_comb begin
        n_kind = i_head.kind;
        if ((i_head.kind == sftd_pkg::KIND_OK) && bad) n_kind = sftd_pkg::KIND_REJECT;
    end

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_lat  <= i_head.lat;
            r_lon  <= i_head.lon;
            r_alt  <= i_head.alt;
            r_cnt  <= i_head.count;
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_kind  = r_kind;
    assign o_latitude    = $signed(r_lat);
    assign o_longitude   = $signed(r_lon);
    assign o_altitude    = $signed(r_alt);
    assign o_good_frames = r_cnt;

endmodule

>>> hw/rtl/status_frame_target_decoder_unit.sv
// status_frame_target_decoder_unit: top level of the status frame target decoder
// holds the config registers and joins parser, queue and result stage
// depends on sftd_pkg, sftd_front, sftd_queue, sftd_back
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------
//  input    | in        | i_valid / o_ready    | i_data_byte, i_datagram_end
//  output   | out       | o_valid / i_ready    | o_frame_kind, o_latitude, o_longitude,
//           |           |                      | o_altitude, o_good_frames
//  config   | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// one byte is taken each cycle while the queue has room; per byte the parser
// does a compare, an xor and a shift; a frame result goes through the queue
// into the output register, which it enters when the output register is free
// o_ready drops only while the two-entry descriptor queue is full
// a stalled output holds the queue; the parser keeps running until the queue fills
// synchronous active-low reset returns to hunting, clears the count and empties the queue
module status_frame_target_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transaction
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_datagram_end,
    // output transaction
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_frame_kind,
    output logic signed [31:0]  o_latitude,
    output logic signed [31:0]  o_longitude,
    output logic signed [15:0]  o_altitude,
    output logic [31:0]         o_good_frames,
    // config writes
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data
);

    // config registers
    logic [7:0]        r_expected_type;
    sftd_pkg::t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_type    <= sftd_pkg::EXPECTED_TYPE_RST;
            r_limits.lat_limit <= sftd_pkg::LAT_LIMIT_RST;
            r_limits.lon_limit <= sftd_pkg::LON_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sftd_pkg::CFG_EXPECTED_TYPE: r_expected_type    <= i_cfg_data[7:0];
                sftd_pkg::CFG_LAT_LIMIT:     r_limits.lat_limit <= i_cfg_data;
                sftd_pkg::CFG_LON_LIMIT:     r_limits.lon_limit <= i_cfg_data;
                default: ; // index beyond the register list is ignored
            endcase
        end
    end

    // front end: accept and classify bytes
    logic            accept;
    logic            push;
    sftd_pkg::t_desc desc;

    // queue between front and back
    logic            q_full;
    logic            q_empty;
    logic            pop;
    sftd_pkg::t_desc head;

    // any byte may close a frame, so the front end only takes one while
    // the queue has room for a descriptor
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    sftd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_datagram_end  (i_datagram_end),
        .i_expected_type (r_expected_type),
        .o_push          (push),
        .o_desc          (desc)
    );

    sftd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // back end: limit check and output register
    sftd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head),
        .i_limits      (r_limits),
        .i_ready       (i_ready),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_frame_kind  (o_frame_kind),
        .o_latitude    (o_latitude),
        .o_longitude   (o_longitude),
        .o_altitude    (o_altitude),
        .o_good_frames (o_good_frames)
    );

endmodule

>>> hw/rtl/sftd_checker.sv
// sftd_checker: port-level assertions for the status frame target decoder
// bound to status_frame_target_decoder_unit; depends on sftd_pkg
module sftd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [2:0]         o_frame_kind,
    input logic signed [31:0] o_latitude,
    input logic signed [31:0] o_longitude,
    input logic signed [15:0] o_altitude
);

    // no result straight out of reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a waiting result is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // bad-checksum, other-type and short frames carry no coordinates
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_kind == sftd_pkg::KIND_CSUM_BAD
                 || o_frame_kind == sftd_pkg::KIND_OTHER
                 || o_frame_kind == sftd_pkg::KIND_SHORT)
        |-> (o_latitude == 32'sd0) && (o_longitude == 32'sd0) && (o_altitude == 16'sd0))
        else $error("coordinates on a failed frame");

    // an accepted target never sits at the origin
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_kind == sftd_pkg::KIND_OK)
        |-> (o_latitude != 32'sd0) || (o_longitude != 32'sd0))
        else $error("origin target accepted");

    // kind code stays within its defined codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_kind <= sftd_pkg::KIND_SHORT))
        else $error("undefined frame kind");

endmodule

bind status_frame_target_decoder_unit sftd_checker u_sftd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_frame_kind (o_frame_kind),
    .o_latitude   (o_latitude),
    .o_longitude  (o_longitude),
    .o_altitude   (o_altitude)
);

>>> bench/status_frame_target_decoder_unit_tb.sv
// status_frame_target_decoder_unit_tb: self-checking bench for the status frame decoder
// streams framed datagram bytes with random gaps and stalls, predicts every frame report
// depends on sftd_pkg and status_frame_target_decoder_unit
module status_frame_target_decoder_unit_tb;

    localparam int RANDOM_BYTES_PER_SETTING = 225;
    localparam int MAX_WAIT = 13;
    // slowest legal run is far below this, even with every byte and report stalled
    localparam int TIMEOUT_TU = 4_000_000;

    // how a generated frame gets damaged
    typedef enum logic [1:0] {
        FR_GOOD,
        FR_BADSUM,
        FR_CUT
    } t_fault;

    typedef struct {
        logic [7:0] data;
        logic       dgram_end;
    } t_stim_byte;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic       in_valid = 1'b0;
    logic       o_ready;
    logic [7:0] in_data = 8'h00;
    logic       in_end = 1'b0;

    // output channel
    logic               o_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         o_frame_kind;
    logic signed [31:0] o_latitude;
    logic signed [31:0] o_longitude;
    logic signed [15:0] o_altitude;
    logic [31:0]        o_good_frames;

    // register write port
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = sftd_pkg::CFG_EXPECTED_TYPE;
    logic [30:0] cfg_data = '0;

    // bytes waiting to be driven, and the frame reports still owed by the block
    t_stim_byte      pending_bytes[$];
    sftd_pkg::t_desc due_reports[$];

    // register copies used by the frame predictor
    logic [7:0]  cfg_type = sftd_pkg::EXPECTED_TYPE_RST;
    logic [30:0] cfg_lat = sftd_pkg::LAT_LIMIT_RST;
    logic [30:0] cfg_lon = sftd_pkg::LON_LIMIT_RST;

    // frame predictor state, reset values
    sftd_pkg::t_phase hunt_state = sftd_pkg::PH_SEARCH;
    logic [5:0]  flen = '0;
    logic [5:0]  bpos = '0;
    logic [7:0]  rxor = '0;
    logic [7:0]  tbyte = '0;
    logic [31:0] lat_sh = '0;
    logic [31:0] lon_sh = '0;
    logic [15:0] alt_sh = '0;
    logic [31:0] good_cnt = '0;

    // bench bookkeeping
    int              errors = 0;
    int              bytes_taken = 0;
    int              framed_bytes = 0;
    int              cfg_writes = 0;
    int              kinds_seen[5] = '{default: 0};
    int              in_wait = 0;
    int              out_stall = 0;
    bit              in_calm = 1'b0;
    bit              out_calm = 1'b0;
    t_stim_byte      staged;
    sftd_pkg::t_desc want;

    status_frame_target_decoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_ready        (o_ready),
        .i_data_byte    (in_data),
        .i_datagram_end (in_end),
        .o_valid        (o_valid),
        .i_ready        (out_ready),
        .o_frame_kind   (o_frame_kind),
        .o_latitude     (o_latitude),
        .o_longitude    (o_longitude),
        .o_altitude     (o_altitude),
        .o_good_frames  (o_good_frames),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // idle cycles before the next transaction; calm stretches run back to back
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // advance the predicted parser by one accepted byte, queue any report it owes
    task automatic track_frame_byte(input logic [7:0] b, input logic dgram_end);
        logic [5:0]      k;
        sftd_pkg::t_desc rep;
        bit              emit;
        emit = 1'b0;
        rep = '0;
        case (hunt_state)
            sftd_pkg::PH_SEARCH: begin
                if (b == sftd_pkg::HDR_FIRST) hunt_state = sftd_pkg::PH_GOT1;
            end
            sftd_pkg::PH_GOT1: begin
                if (b == sftd_pkg::HDR_SECOND) hunt_state = sftd_pkg::PH_GOT2;
                else hunt_state = (b == sftd_pkg::HDR_FIRST) ? sftd_pkg::PH_GOT1
                                                             : sftd_pkg::PH_SEARCH;
            end
            sftd_pkg::PH_GOT2: begin
                if (b == sftd_pkg::HDR_THIRD) hunt_state = sftd_pkg::PH_LEN;
                else hunt_state = (b == sftd_pkg::HDR_FIRST) ? sftd_pkg::PH_GOT1
                                                             : sftd_pkg::PH_SEARCH;
            end
            sftd_pkg::PH_LEN: begin
                // length code too small to hold a type and a checksum
                if (b[5:0] < sftd_pkg::MIN_LEN) begin
                    rep.kind = sftd_pkg::KIND_SHORT;
                    emit = 1'b1;
                    hunt_state = sftd_pkg::PH_SEARCH;
                end else begin
                    flen = b[5:0];
                    rxor = b;
                    bpos = '0;
                    tbyte = '0;
                    lat_sh = '0;
                    lon_sh = '0;
                    alt_sh = '0;
                    hunt_state = sftd_pkg::PH_FRAME;
                end
            end
            sftd_pkg::PH_FRAME: begin
                k = bpos;
                if (k == flen - 6'd2) begin
                    // checksum byte closes the frame; checksum wins over type
                    emit = 1'b1;
                    hunt_state = sftd_pkg::PH_SEARCH;
                    if (b != rxor) begin
                        rep.kind = sftd_pkg::KIND_CSUM_BAD;
                    end else if (tbyte != cfg_type) begin
                        rep.kind = sftd_pkg::KIND_OTHER;
                    end else begin
                        good_cnt = good_cnt + 32'd1;
                        if (flen < sftd_pkg::MIN_FULL_LEN) begin
                            rep.kind = sftd_pkg::KIND_SHORT;
                        end else begin
                            rep.lat = lat_sh;
                            rep.lon = lon_sh;
                            rep.alt = alt_sh;
                            rep.kind = ((lat_sh == 0 && lon_sh == 0) ||
                                        magnitude(lat_sh) > {1'b0, cfg_lat} ||
                                        magnitude(lon_sh) > {1'b0, cfg_lon}) ?
                                       sftd_pkg::KIND_REJECT : sftd_pkg::KIND_OK;
                        end
                    end
                end else begin
                    rxor = rxor ^ b;
                    // body byte n sits at position n + 1
                    if (k == 0) tbyte = b;
                    else if (k >= 13 && k <= 16) lat_sh = {lat_sh[23:0], b};
                    else if (k >= 17 && k <= 20) lon_sh = {lon_sh[23:0], b};
                    else if (k == 21 || k == 22) alt_sh = {alt_sh[7:0], b};
                    bpos = k + 6'd1;
                end
            end
            default: hunt_state = sftd_pkg::PH_SEARCH;
        endcase
        // end of datagram always drops back to hunting
        if (dgram_end) hunt_state = sftd_pkg::PH_SEARCH;
        if (emit) begin
            rep.count = good_cnt;
            due_reports.push_back(rep);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic dgram_end);
        t_stim_byte s;
        s.data = b;
        s.dgram_end = dgram_end;
        pending_bytes.push_back(s);
    endtask

    // header, length byte, type, body with coordinates at bytes 12..21, checksum
    task automatic push_frame(input logic [7:0] len_byte, input logic [7:0] ftype,
                              input logic [31:0] lat, input logic [31:0] lon,
                              input logic [15:0] alt, input t_fault fault,
                              input bit end_after);
        logic [7:0] fr[$];
        logic [7:0] sum;
        logic [7:0] bb;
        int         body_len;
        int         cut_at;
        fr = '{sftd_pkg::HDR_FIRST, sftd_pkg::HDR_SECOND, sftd_pkg::HDR_THIRD, len_byte};
        if (len_byte[5:0] >= sftd_pkg::MIN_LEN) begin
            body_len = int'(len_byte[5:0]) - 3;
            sum = len_byte ^ ftype;
            fr.push_back(ftype);
            for (int i = 0; i < body_len; i++) begin
                if (i >= 12 && i <= 15) bb = lat[8 * (15 - i) +: 8];
                else if (i >= 16 && i <= 19) bb = lon[8 * (19 - i) +: 8];
                else if (i >= 20 && i <= 21) bb = alt[8 * (21 - i) +: 8];
                else bb = 8'($urandom());
                sum = sum ^ bb;
                fr.push_back(bb);
            end
            if (fault == FR_BADSUM) sum = sum ^ 8'($urandom_range(1, 255));
            fr.push_back(sum);
        end
        // a cut frame loses its tail at a datagram end
        cut_at = (fault == FR_CUT) ? int'($urandom_range(0, fr.size() - 2)) : fr.size() - 1;
        for (int i = 0; i <= cut_at; i++)
            push_byte(fr[i], (i == cut_at) && (end_after || fault == FR_CUT));
        framed_bytes += cut_at + 1;
    endtask

    // coordinate biased toward the limit edges, zero and the int32 extremes
    function automatic logic [31:0] pick_coord(input logic [30:0] lim);
        logic [31:0] r;
        case ($urandom_range(0, 11))
            0: r = '0;
            1: r = {1'b0, lim};
            2: r = {1'b0, lim} + 32'd1;
            3: r = -{1'b0, lim};
            4: r = -({1'b0, lim} + 32'd1);
            5: r = 32'h8000_0000;
            6: r = 32'h7FFF_FFFF;
            7: r = $urandom();
            default: begin
                r = $urandom() % ({1'b0, lim} + 32'd1);
                if ($urandom_range(0, 1) == 1) r = -r;
            end
        endcase
        return r;
    endfunction

    task automatic random_frame(input t_fault fault);
        logic [5:0] code;
        logic [1:0] top_bits;
        logic [7:0] ftype;
        int         pick;
        pick = $urandom_range(0, 99);
        // mostly full status frames, some short bodies, a few long or bad lengths
        if (pick < 55) code = 6'($urandom_range(25, 29));
        else if (pick < 75) code = 6'($urandom_range(3, 24));
        else if (pick < 92) code = 6'($urandom_range(30, 63));
        else code = 6'($urandom_range(0, 2));
        top_bits = 2'($urandom_range(0, 3));
        ftype = ($urandom_range(0, 4) != 0) ? cfg_type : 8'($urandom());
        push_frame({top_bits, code}, ftype, pick_coord(cfg_lat), pick_coord(cfg_lon),
                   16'($urandom()), fault, $urandom_range(0, 1) == 1);
    endtask

    task automatic random_traffic(input int n_bytes);
        int start;
        int pick;
        logic [7:0] b;
        start = framed_bytes;
        while (framed_bytes - start < n_bytes) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                random_frame(FR_GOOD);
            end else if (pick < 15) begin
                random_frame(FR_BADSUM);
            end else if (pick < 17) begin
                random_frame(FR_CUT);
            end else if (pick < 18) begin
                // line noise between frames
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom()), $urandom_range(0, 7) == 0);
            end else begin
                // header broken at its second or third byte
                push_byte(sftd_pkg::HDR_FIRST, 1'b0);
                if ($urandom_range(0, 1) == 1) push_byte(sftd_pkg::HDR_SECOND, 1'b0);
                b = 8'($urandom());
                if (b == sftd_pkg::HDR_SECOND || b == sftd_pkg::HDR_THIRD) b = 8'h00;
                push_byte(b, $urandom_range(0, 3) == 0);
            end
        end
        // close the datagram so the next setting starts from hunting
        push_byte(8'($urandom()), 1'b1);
    endtask

    // wait until every byte is taken and every report is back, then let the pipe settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || due_reports.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            sftd_pkg::CFG_EXPECTED_TYPE: cfg_type = value[7:0];
            sftd_pkg::CFG_LAT_LIMIT:     cfg_lat = value;
            sftd_pkg::CFG_LON_LIMIT:     cfg_lon = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // input driver: one byte per transaction, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_wait = 0;
        end else begin
            if (in_valid && o_ready) begin
                // transaction accepted: predict from the bytes that were on the bus
                track_frame_byte(in_data, in_end);
                bytes_taken++;
                in_wait = draw_wait(in_calm);
                if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
            end
            if (!in_valid || o_ready) begin
                if (in_wait != 0) begin
                    in_wait--;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    staged = pending_bytes.pop_front();
                    in_data <= staged.data;
                    in_end <= staged.dgram_end;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: random stalls on ready, each report checked against the oldest due
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_valid && out_ready) begin
                if (o_frame_kind <= 3'd4) kinds_seen[o_frame_kind]++;
                if (due_reports.size() == 0) begin
                    $display("%0t: report with none due, kind %0d count %0d",
                             $time, o_frame_kind, o_good_frames);
                    errors++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("frame_kind", 32'(want.kind), 32'(o_frame_kind));
                    check_field("latitude", want.lat, o_latitude);
                    check_field("longitude", want.lon, o_longitude);
                    check_field("altitude", 32'(want.alt), 32'($unsigned(o_altitude)));
                    check_field("good_frames", want.count, o_good_frames);
                end
                out_stall = draw_wait(out_calm);
                if ($urandom_range(0, 7) == 0) out_calm = !out_calm;
            end
            if (out_stall != 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at the reset settings
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // resync: a first header byte inside a broken header starts a new header
        push_byte(sftd_pkg::HDR_FIRST, 1'b0);
        push_byte(sftd_pkg::HDR_SECOND, 1'b0);
        push_byte(sftd_pkg::HDR_FIRST, 1'b0);
        push_frame(8'h19, sftd_pkg::EXPECTED_TYPE_RST, 32'd1, -32'd1, 16'h7FFF, FR_GOOD, 1'b0);
        push_byte(sftd_pkg::HDR_FIRST, 1'b0);
        push_byte(sftd_pkg::HDR_SECOND, 1'b0);
        push_byte(8'h00, 1'b0);
        // length codes below three, upper length bits set on some
        push_frame(8'h00, sftd_pkg::EXPECTED_TYPE_RST, '0, '0, '0, FR_GOOD, 1'b0);
        push_frame(8'hC2, sftd_pkg::EXPECTED_TYPE_RST, '0, '0, '0, FR_GOOD, 1'b0);
        push_frame(8'h41, sftd_pkg::EXPECTED_TYPE_RST, '0, '0, '0, FR_GOOD, 1'b1);
        // counted status frames with bodies too short for coordinates
        push_frame(8'h03, sftd_pkg::EXPECTED_TYPE_RST, '0, '0, '0, FR_GOOD, 1'b0);
        push_frame(8'h18, sftd_pkg::EXPECTED_TYPE_RST, 32'd5, 32'd5, 16'd5, FR_GOOD, 1'b0);
        // zero position rejected, one zero axis accepted
        push_frame(8'h19, sftd_pkg::EXPECTED_TYPE_RST, '0, '0, 16'h8000, FR_GOOD, 1'b0);
        push_frame(8'h59, sftd_pkg::EXPECTED_TYPE_RST, '0, 32'd77, 16'h0000, FR_GOOD, 1'b0);
        // limits exactly met, then exceeded by one, then int32 minimum
        push_frame(8'h19, sftd_pkg::EXPECTED_TYPE_RST, {1'b0, sftd_pkg::LAT_LIMIT_RST},
                   -{1'b0, sftd_pkg::LON_LIMIT_RST}, 16'hFFFF, FR_GOOD, 1'b0);
        push_frame(8'h1A, sftd_pkg::EXPECTED_TYPE_RST, {1'b0, sftd_pkg::LAT_LIMIT_RST} + 32'd1,
                   32'd1, 16'h0001, FR_GOOD, 1'b0);
        push_frame(8'h19, sftd_pkg::EXPECTED_TYPE_RST, 32'd1,
                   -({1'b0, sftd_pkg::LON_LIMIT_RST} + 32'd1), 16'h1234, FR_GOOD, 1'b0);
        push_frame(8'h19, sftd_pkg::EXPECTED_TYPE_RST, 32'h8000_0000, 32'd1, 16'h0000,
                   FR_GOOD, 1'b1);
        // bad checksum, foreign type, frame cut by a datagram end
        push_frame(8'h19, sftd_pkg::EXPECTED_TYPE_RST, 32'd9, 32'd9, 16'd9, FR_BADSUM, 1'b0);
        push_frame(8'h1A, 8'h41, 32'd9, 32'd9, 16'd9, FR_GOOD, 1'b0);
        push_frame(8'h1B, sftd_pkg::EXPECTED_TYPE_RST, 32'd9, 32'd9, 16'd9, FR_CUT, 1'b0);
        // datagram end on a header byte, then the longest frame
        push_byte(sftd_pkg::HDR_FIRST, 1'b1);
        push_frame(8'hFF, sftd_pkg::EXPECTED_TYPE_RST, -32'd100, 32'd100, 16'd100,
                   FR_GOOD, 1'b1);

        random_traffic(RANDOM_BYTES_PER_SETTING);
        wait_idle();

        // type zero, latitude limit zero, widest longitude limit
        write_reg(sftd_pkg::CFG_EXPECTED_TYPE, 31'h00);
        write_reg(sftd_pkg::CFG_LAT_LIMIT, 31'd0);
        write_reg(sftd_pkg::CFG_LON_LIMIT, 31'h7FFF_FFFF);
        random_traffic(RANDOM_BYTES_PER_SETTING);
        wait_idle();

        // type all ones, widest latitude limit, longitude limit zero
        write_reg(sftd_pkg::CFG_EXPECTED_TYPE, 31'hFF);
        write_reg(sftd_pkg::CFG_LAT_LIMIT, 31'h7FFF_FFFF);
        write_reg(sftd_pkg::CFG_LON_LIMIT, 31'd0);
        random_traffic(RANDOM_BYTES_PER_SETTING);
        wait_idle();

        // arbitrary settings
        write_reg(sftd_pkg::CFG_EXPECTED_TYPE, 31'($urandom_range(0, 255)));
        write_reg(sftd_pkg::CFG_LAT_LIMIT, 31'($urandom()));
        write_reg(sftd_pkg::CFG_LON_LIMIT, 31'($urandom()));
        random_traffic(RANDOM_BYTES_PER_SETTING);
        wait_idle();

        $display("run took %0d byte transactions under 4 settings after %0d register writes",
                 bytes_taken, cfg_writes);
        $display("reports: ok %0d, rejected %0d, bad checksum %0d, other type %0d, short %0d",
                 kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4]);
        if (errors == 0 && due_reports.size() == 0) begin
            $display("** status_frame_target_decoder_unit: PASSED **");
        end else begin
            $display("** status_frame_target_decoder_unit: FAILED **");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(TIMEOUT_TU);
        $display("timeout with %0d reports still due", due_reports.size());
        $display("** status_frame_target_decoder_unit: FAILED **");
        $finish;
    end

endmodule
